// ----- rtl/core/psfb_pkg.sv -----
// shared constants for the per-source flood blocker
`default_nettype none
package psfb_pkg;
    localparam int SOURCE_ENTRIES    = 64;
    localparam int BLACKLIST_ENTRIES = 64;
    localparam int SRC_AW = $clog2(SOURCE_ENTRIES);
    localparam int BLK_AW = $clog2(BLACKLIST_ENTRIES);
    localparam logic [15:0] IPV4_KIND       = 16'h0800;
    localparam logic [15:0] THRESHOLD_RESET = 16'd1000;
    localparam logic [15:0] COUNT_MAX       = 16'hFFFF;
    localparam logic        CFG_PROTECTED   = 1'b0;
    localparam logic        CFG_THRESHOLD   = 1'b1;
    localparam logic        CMD_PACKET      = 1'b0;
    localparam logic        CMD_TICK        = 1'b1;
    localparam logic [1:0]  REASON_NONE     = 2'd0;
    localparam logic [1:0]  REASON_RATE     = 2'd1;
    localparam logic [1:0]  REASON_PAYLOAD  = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/core/psfb_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module psfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/per_source_flood_blocker.sv -----
// per-source flood blocker: sequencer over the source, count and blacklist rams
// ipv4 packet words to the protected address scan the source table, then the
// blacklist for known sources; a tick sweeps the count table and clears it;
// other words go straight to the result; one word at a time, in_stall is high
// while busy or while a result waits; reset clears fill counts and prot_reg,
// loads thr_reg with THRESHOLD_RESET; ram contents stay undefined until written
`default_nettype none
module per_source_flood_blocker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [15:0] ether_kind,
    input  wire logic [31:0] destination_address,
    input  wire logic [31:0] source_address,
    input  wire logic        payload_suspicious,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             block_now,
    output logic [1:0]       block_reason,
    output logic [31:0]      blocked_address,
    output logic             source_is_new,
    output logic             table_overflow
);
    import psfb_pkg::*;

    typedef enum logic [2:0] {IDLE, TSCAN, CREAD, BSCAN, TICK, DONE} state_t;
    state_t state_reg;

    logic [31:0] prot_reg;
    logic [15:0] thr_reg;
    logic [SRC_AW:0] tused_reg;
    logic [BLK_AW:0] bused_reg;
    logic [SRC_AW:0] idx_reg;
    logic [SRC_AW-1:0] slot_reg;
    logic [31:0] src_reg;
    logic susp_reg, rate_reg;
    logic [BLK_AW:0] bidx_reg;

    // ram ports
    logic ta_we, tc_we, bl_we;
    logic [SRC_AW-1:0] ta_waddr, tc_waddr, ta_raddr, tc_raddr;
    logic [31:0] ta_wdata, ta_rdata, bl_rdata;
    logic [15:0] tc_wdata, tc_rdata;
    logic [BLK_AW-1:0] bl_raddr;

    psfb_ram #(.WIDTH(32), .DEPTH(SOURCE_ENTRIES)) u_addr (.clk(clk), .we(ta_we),
        .waddr(ta_waddr), .wdata(ta_wdata), .raddr(ta_raddr), .rdata(ta_rdata));
    psfb_ram #(.WIDTH(16), .DEPTH(SOURCE_ENTRIES)) u_cnt (.clk(clk), .we(tc_we),
        .waddr(tc_waddr), .wdata(tc_wdata), .raddr(tc_raddr), .rdata(tc_rdata));
    psfb_ram #(.WIDTH(32), .DEPTH(BLACKLIST_ENTRIES)) u_blk (.clk(clk), .we(bl_we),
        .waddr(bused_reg[BLK_AW-1:0]), .wdata(src_reg), .raddr(bl_raddr),
        .rdata(bl_rdata));

    logic [15:0] cnt_inc;
    logic        rate_hit;
    logic        tsc_valid, bsc_valid;
    // entry idx-1 data is on rdata while scanning
    assign tsc_valid = (idx_reg != '0);
    assign bsc_valid = (bidx_reg != '0);
    assign cnt_inc  = (tc_rdata < COUNT_MAX) ? tc_rdata + 16'd1 : tc_rdata;
    assign rate_hit = cnt_inc > thr_reg;

    // a waiting result holds off the next word
    assign in_stall = (state_reg != IDLE) || (out_valid && out_stall);

    always_comb
    begin
        ta_we = 1'b0; tc_we = 1'b0; bl_we = 1'b0;
        ta_waddr = tused_reg[SRC_AW-1:0]; ta_wdata = src_reg;
        tc_waddr = tused_reg[SRC_AW-1:0]; tc_wdata = 16'd1;
        ta_raddr = idx_reg[SRC_AW-1:0]; tc_raddr = slot_reg;
        bl_raddr = bidx_reg[BLK_AW-1:0];
        case (state_reg)
            TSCAN:
            begin
                tc_raddr = SRC_AW'(idx_reg - 1'b1);
                if (!(tsc_valid && ta_rdata == src_reg) && idx_reg >= tused_reg
                    && tused_reg < (SRC_AW+1)'(SOURCE_ENTRIES))
                begin
                    ta_we = 1'b1; tc_we = 1'b1;
                end
            end
            CREAD:
            begin
                tc_we = 1'b1; tc_waddr = slot_reg; tc_wdata = cnt_inc;
            end
            BSCAN:
            begin
                if (!(bsc_valid && bl_rdata == src_reg) && bidx_reg >= bused_reg
                    && (rate_reg || susp_reg)
                    && bused_reg < (BLK_AW+1)'(BLACKLIST_ENTRIES))
                begin
                    bl_we = 1'b1;
                end
            end
            TICK:
            begin
                if (idx_reg < tused_reg)
                begin
                    tc_we = 1'b1; tc_waddr = idx_reg[SRC_AW-1:0]; tc_wdata = 16'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            prot_reg <= '0;
            thr_reg <= THRESHOLD_RESET;
            tused_reg <= '0;
            bused_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PROTECTED) prot_reg <= cfg_data;
                else thr_reg <= cfg_data[15:0];
            end
            case (state_reg)
                IDLE:
                begin
                    if (out_valid && !out_stall) out_valid <= 1'b0;
                    if (in_valid && !in_stall)
                    begin
                        src_reg <= source_address;
                        susp_reg <= payload_suspicious;
                        idx_reg <= '0;
                        bidx_reg <= '0;
                        block_now <= 1'b0; block_reason <= REASON_NONE;
                        blocked_address <= '0; source_is_new <= 1'b0;
                        table_overflow <= 1'b0;
                        if (command == CMD_TICK) state_reg <= TICK;
                        else if (ether_kind == IPV4_KIND
                                 && destination_address == prot_reg)
                            state_reg <= TSCAN;
                        else state_reg <= DONE;
                    end
                end
                TSCAN:
                begin
                    if (tsc_valid && ta_rdata == src_reg)
                    begin
                        slot_reg <= SRC_AW'(idx_reg - 1'b1);
                        state_reg <= CREAD;
                    end
                    else if (idx_reg >= tused_reg)
                    begin
                        if (tused_reg < (SRC_AW+1)'(SOURCE_ENTRIES))
                        begin
                            tused_reg <= tused_reg + 1'b1;
                            source_is_new <= 1'b1;
                        end
                        else table_overflow <= 1'b1;
                        state_reg <= DONE;
                    end
                    else idx_reg <= idx_reg + 1'b1;
                end
                CREAD:
                begin
                    // count read was issued at the match cycle
                    rate_reg <= rate_hit;
                    state_reg <= BSCAN;
                end
                BSCAN:
                begin
                    if (bsc_valid && bl_rdata == src_reg) state_reg <= DONE;
                    else if (bidx_reg >= bused_reg)
                    begin
                        if (rate_reg || susp_reg)
                        begin
                            if (bused_reg < (BLK_AW+1)'(BLACKLIST_ENTRIES))
                            begin
                                bused_reg <= bused_reg + 1'b1;
                                block_now <= 1'b1;
                                block_reason <= rate_reg ? REASON_RATE : REASON_PAYLOAD;
                                blocked_address <= src_reg;
                            end
                            else table_overflow <= 1'b1;
                        end
                        state_reg <= DONE;
                    end
                    else bidx_reg <= bidx_reg + 1'b1;
                end
                TICK:
                begin
                    if (idx_reg >= tused_reg) state_reg <= DONE;
                    else idx_reg <= idx_reg + 1'b1;
                end
                DONE:
                begin
                    out_valid <= 1'b1;
                    state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
